// File: rtl/qdiv_pkg.sv
`timescale 1ns / 1ps
package qdiv_pkg;
  localparam int OUT_W = 24;
  localparam int QB = OUT_W;
  localparam logic [OUT_W-1:0] LIM = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] LIM_M1 = {1'b0, {(OUT_W-1){1'b1}}};
endpackage

// File: rtl/qdiv_mult.sv
`timescale 1ns / 1ps
// Three stages: input register, 20 products, signed sums.
module qdiv_mult #(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [W-1:0]     q [4],
  input  logic signed [W-1:0]     r [4],
  output logic signed [2*W+1:0]   num [4],
  output logic [2*W:0]            nrm
);
  localparam int NW = 2 * W + 2;

  logic signed [W-1:0]   qa [4];
  logic signed [W-1:0]   ra [4];
  logic signed [2*W-1:0] p [4][4];
  logic signed [2*W-1:0] sq [4];
  logic signed [NW-1:0]  nsum;

  always_ff @(posedge clk) begin
    if (en) begin
      qa <= q;
      ra <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq[i] <= ra[i] * ra[i];
        for (int j = 0; j < 4; j++) p[i][j] <= ra[i] * qa[j];
      end
    end
  end

  // conj(r) * q, r index first
  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= NW'(p[0][0]) + NW'(p[1][1]) + NW'(p[2][2]) + NW'(p[3][3]);
      num[1] <= NW'(p[0][1]) - NW'(p[1][0]) - NW'(p[2][3]) + NW'(p[3][2]);
      num[2] <= NW'(p[0][2]) + NW'(p[1][3]) - NW'(p[2][0]) - NW'(p[3][1]);
      num[3] <= NW'(p[0][3]) - NW'(p[1][2]) + NW'(p[2][1]) - NW'(p[3][0]);
      nrm    <= nsum[2*W:0];
    end
  end

  assign nsum = NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2]) + NW'(sq[3]);
endmodule

// File: rtl/qdiv_lane.sv
`timescale 1ns / 1ps
// One component: setup stage, one quotient bit per stage, round/saturate stage.
module qdiv_lane #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [2*W+1:0]          num,
  input  logic [2*W:0]                   nrm,
  output logic [qdiv_pkg::OUT_W-1:0]     p,
  output logic                           dz
);
  localparam int QB  = qdiv_pkg::QB;
  localparam int MW  = 2 * W + 1;
  localparam int NWD = MW + F + 2;
  localparam int D2W = 2 * W + 2;
  localparam int RW  = ((NWD > D2W + QB) ? NWD : D2W + QB) + 1;

  logic [MW-1:0]  mag;
  logic [RW-1:0]  n_ext;
  logic [RW-1:0]  d2_ext;
  logic [RW-1:0]  rem [QB+1];
  logic [D2W-1:0] d2 [QB+1];
  logic [QB-1:0]  quo [QB+1];
  logic           neg [QB+1];
  logic           zer [QB+1];
  logic           ovf [QB+1];
  logic [QB-1:0]  sat;

  assign mag    = num[2*W+1] ? MW'(-num) : num[MW-1:0];
  assign n_ext  = RW'({mag, {(F+1){1'b0}}}) + RW'(nrm);
  assign d2_ext = RW'({nrm, 1'b0}) << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n_ext;
      d2[0]  <= {nrm, 1'b0};
      quo[0] <= '0;
      neg[0] <= num[2*W+1];
      zer[0] <= (nrm == '0);
      ovf[0] <= (n_ext >= d2_ext);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int B = QB - 1 - k;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(d2[k]) << B;
    assign take  = rem[k] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? rem[k] - trial : rem[k];
        quo[k+1] <= quo[k] | (take ? (QB'(1) << B) : '0);
        d2[k+1]  <= d2[k];
        neg[k+1] <= neg[k];
        zer[k+1] <= zer[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign sat = (ovf[QB] || quo[QB] > qdiv_pkg::LIM) ? qdiv_pkg::LIM : quo[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      dz <= zer[QB];
      if (zer[QB]) begin
        p <= '0;
      end else if (neg[QB]) begin
        p <= -sat;
      end else begin
        p <= (sat > qdiv_pkg::LIM_M1) ? qdiv_pkg::LIM_M1 : sat;
      end
    end
  end
endmodule

// File: rtl/quaternion_divide.sv
`timescale 1ns / 1ps
// channel | beat fields (low bit up)                     | notes
// s_*     | q_w q_x q_y q_z r_w r_x r_y r_z, IN_WIDTH each | dividend, divisor
// m_*     | p_w p_x p_y p_z, 24 each; tuser = div_zero     | quotient, Q.FRAC_BITS
// Stages in order: multiply/sum, setup, one per quotient bit, round.
// One beat per cycle sustained while the output is empty or taken; the 24-stage restoring divider sets the depth.
// rst clears only the valid bits; data registers are not reset.
// The whole pipe advances when the output is empty or taken, so a stall
// holds every stage in place.
module quaternion_divide #(
  parameter int IN_WIDTH  = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z
  input  logic [((8*IN_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // p_w, p_x, p_y, p_z
  output logic [4*qdiv_pkg::OUT_W-1:0] m_tdata,
  // div_zero
  output logic m_tuser
);
  localparam int W     = IN_WIDTH;
  localparam int DEPTH = 3 + qdiv_pkg::QB + 2;

  logic                   en;
  logic [DEPTH-1:0]       vld;
  logic signed [W-1:0]    q [4];
  logic signed [W-1:0]    r [4];
  logic signed [2*W+1:0]  num [4];
  logic [2*W:0]           nrm;
  logic [3:0]             dz;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];
  assign m_tuser  = dz[0];

  for (genvar i = 0; i < 4; i++) begin : g_in
    assign q[i] = s_tdata[i*W +: W];
    assign r[i] = s_tdata[(i+4)*W +: W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  qdiv_mult #(.W(W)) u_mult (
    .clk(clk), .en(en), .q(q), .r(r), .num(num), .nrm(nrm)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qdiv_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .num(num[i]), .nrm(nrm),
      .p(m_tdata[i*qdiv_pkg::OUT_W +: qdiv_pkg::OUT_W]), .dz(dz[i])
    );
  end

`ifndef ASSERT_OFF
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0) else $error("div_zero beat with data");
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> dz == 4'b0000 || dz == 4'b1111) else $error("lane flags differ");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("output valid after reset");
`endif
endmodule

// File: tb/sv/quaternion_divide_checker.sv
`timescale 1ns / 1ps
module quaternion_divide_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic                       div_zero;
    logic [qdiv_pkg::OUT_W-1:0] p_z;
    logic [qdiv_pkg::OUT_W-1:0] p_y;
    logic [qdiv_pkg::OUT_W-1:0] p_x;
    logic [qdiv_pkg::OUT_W-1:0] p_w;
  } quotient_t;

  quotient_t quotient_q[$];

  // round half away from zero, saturate to OUT_W
  function automatic logic [qdiv_pkg::OUT_W-1:0] scaled_div(longint num, longint den);
    logic signed [127:0] n, d, mag, res;
    logic neg;
    n = num;
    d = den;
    neg = n < 0;
    mag = neg ? -n : n;
    mag = ((mag <<< 15) + d) / (d <<< 1);
    res = neg ? -mag : mag;
    if (res > $signed({1'b0, qdiv_pkg::LIM_M1})) return qdiv_pkg::LIM_M1;
    if (res < -$signed({1'b0, qdiv_pkg::LIM})) return qdiv_pkg::LIM;
    return res[qdiv_pkg::OUT_W-1:0];
  endfunction

  function automatic quotient_t predict_quotient(logic [127:0] d);
    longint qw, qx, qy, qz, rw, rx, ry, rz, nrm;
    quotient_t p;
    qw = $signed(d[15:0]);    qx = $signed(d[31:16]);
    qy = $signed(d[47:32]);   qz = $signed(d[63:48]);
    rw = $signed(d[79:64]);   rx = $signed(d[95:80]);
    ry = $signed(d[111:96]);  rz = $signed(d[127:112]);
    nrm = rw*rw + rx*rx + ry*ry + rz*rz;
    p = '0;
    if (nrm == 0) begin
      p.div_zero = 1'b1;
      return p;
    end
    p.p_w = scaled_div(rw*qw + rx*qx + ry*qy + rz*qz, nrm);
    p.p_x = scaled_div(rw*qx - rx*qw - ry*qz + rz*qy, nrm);
    p.p_y = scaled_div(rw*qy + rx*qz - ry*qw - rz*qx, nrm);
    p.p_z = scaled_div(rw*qz - rx*qy + ry*qx - rz*qw, nrm);
    return p;
  endfunction

  task automatic cmp(string name, logic [qdiv_pkg::OUT_W-1:0] e,
                     logic [qdiv_pkg::OUT_W-1:0] a);
    if (e !== a) begin
      $error("%s: expected %0d actual %0d", name, $signed(e), $signed(a));
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending = quotient_q.size();

  always @(posedge clk) begin
    quotient_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) quotient_q.push_back(predict_quotient(s_tdata));
      if (m_tvalid && m_tready) begin
        if (quotient_q.size() == 0) begin
          $error("output beat with no expected quotient");
          fail_count++;
        end else begin
          e = quotient_q.pop_front();
          cmp("p_w", e.p_w, m_tdata[23:0]);
          cmp("p_x", e.p_x, m_tdata[47:24]);
          cmp("p_y", e.p_y, m_tdata[71:48]);
          cmp("p_z", e.p_z, m_tdata[95:72]);
          if (e.div_zero !== m_tuser) begin
            $error("div_zero: expected %0d actual %0d", e.div_zero, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [127:0] s_tdata;
  logic [95:0]  m_tdata;
  int           fail_count, pending;
  int           send_idle, recv_idle;

  quaternion_divide u_dut (.*);
  quaternion_divide_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("quaternion_divide test failed");
    $finish;
  end

  // receiver stall
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // leaves tvalid high after the accepting edge; the next call or the caller drops it
  task automatic send_beat(logic [127:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    logic [127:0] d;
    int wait_cnt;
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0;
    send_idle = 7; recv_idle = 88;
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed: extremes, zero divisor, unit divisor, ties
    send_beat({64'h0, 64'h7fff_7fff_7fff_7fff});
    send_beat({64'h0, 64'h0});
    send_beat({64'h0000_0000_0000_4000, 64'h8000_7fff_8000_7fff});
    send_beat({64'h0000_0000_0000_0001, 64'h7fff_8000_7fff_8000});
    send_beat({64'h0000_0000_0000_0001, 64'h8000_8000_8000_8000});
    send_beat({64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff});
    send_beat({64'h7fff_7fff_7fff_7fff, 64'h8000_0001_ffff_0000});
    send_beat({64'h0000_0000_0000_0003, 64'h0001_ffff_0002_fffe});
    send_beat({64'h0000_0000_0002_0000, 64'h0001_0001_0001_0001});
    send_beat({64'hffff_0001_ffff_0001, 64'h0005_fffb_0003_fffd});
    send_beat({64'h4000_0000_0000_0000, 64'h1234_8000_7fff_0000});
    send_beat({64'h0000_0000_0000_ffff, 64'hffff_ffff_ffff_ffff});
    for (int i = 0; i < 550; i++) begin
      if (i == 180) begin send_idle = 88; recv_idle = 7; end
      if (i == 360) begin send_idle = 0; recv_idle = 0; end
      for (int k = 0; k < 8; k++)
        d[16*k +: 16] = ($urandom_range(3) == 0) ? pick_comp() : 16'($urandom);
      if ($urandom_range(40) == 0) d[127:64] = '0;
      send_beat(d);
    end
    s_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("quaternion_divide test passed");
    else
      $display("quaternion_divide test failed");
    $finish;
  end
endmodule

// File: sim.f
rtl/qdiv_pkg.sv
rtl/qdiv_mult.sv
rtl/qdiv_lane.sv
rtl/quaternion_divide.sv
tb/sv/quaternion_divide_checker.sv
tb/sv/tb_top.sv
